// ----- design/pcc_pkg.sv -----
// pcc_pkg: shared types, codes and constants of the palette color cycler
// no dependencies; imported by every module of the block

package pcc_pkg;

    localparam int NUM_RANGES_DEF = 4;
    localparam int MAX_CELLS_DEF  = 16;
    localparam int MAX_COLORS_DEF = 16;

    localparam int OP_W        = 2;
    localparam int RSEL_W      = 2;
    localparam int ESEL_W      = 4;
    localparam int RATE_W      = 15;
    localparam int CCNT_W      = 5;
    localparam int NCELL_W     = 5;
    localparam int REG_W       = 5;
    localparam int START_POS_W = 4;
    localparam int COLOR_W     = 12;

    localparam int INC_W       = 16;
    localparam int RANGES_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int PHASE_W     = 17;
    localparam int PHASE_MAX   = 131071;

    localparam logic [INC_W-1:0]    INC_RESET    = INC_W'((1 << 16) / 50);
    localparam logic [RANGES_W-1:0] RANGES_RESET = RANGES_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SETUP = 2'd1,
        OP_CELL  = 2'd2,
        OP_COLOR = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC     = 1'b0,
        CFG_RANGES_IN_USE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PHASE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic phase;
        logic walk;
        logic walk_last;
    } t_dp_cmd;

    typedef struct packed {
        logic fire;
        logic has_cells;
        logic cell_end;
    } t_dp_sts;

endpackage

// ----- design/pcc_ctrl.sv -----
// pcc_ctrl: sequencer of the color cycler, phase pass then cell walk
// depends on pcc_pkg; drives pcc_datapath through command and status

module pcc_ctrl import pcc_pkg::*; #(
    parameter int NUM_RANGES = NUM_RANGES_DEF,
    parameter int MAX_CELLS  = MAX_CELLS_DEF,
    parameter int RW         = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1,
    parameter int CW         = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [OP_W-1:0]      i_op,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RANGES_W-1:0]  i_cfg_ranges,
    input  t_dp_sts              i_sts,
    output t_dp_cmd              o_cmd,
    output logic [RW-1:0]        o_rng,
    output logic [CW-1:0]        o_cell,
    output logic                 o_busy
);

    t_state                r_state, n_state;
    logic [RANGES_W-1:0]   r_ranges;
    logic [RW-1:0]         r_rng, n_rng;
    logic [RW-1:0]         r_rng_end, n_rng_end;
    logic [RW-1:0]         r_last_rng, n_last_rng;
    logic [CW-1:0]         r_cell, n_cell;
    logic [NUM_RANGES-1:0] r_act, n_act;
    logic                  r_any, n_any;

    logic accept, tick, act_now, walk_act, at_end, walk_done;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign tick      = accept && (t_op'(i_op) == OP_TICK);
    assign act_now   = i_sts.fire && i_sts.has_cells;
    assign walk_act  = r_act[r_rng];
    assign at_end    = (r_rng == r_rng_end);
    assign walk_done = walk_act && i_sts.cell_end && (r_rng == r_last_rng);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (tick) n_state = ST_PHASE;
            ST_PHASE: if (at_end) n_state = (r_any || act_now) ? ST_WALK : ST_IDLE;
            ST_WALK:  if (walk_done) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.load      = accept && (t_op'(i_op) != OP_TICK);
        o_cmd.phase     = (r_state == ST_PHASE);
        o_cmd.walk      = (r_state == ST_WALK) && walk_act;
        o_cmd.walk_last = (r_state == ST_WALK) && walk_done;
        o_busy          = (r_state != ST_IDLE);
    end

    assign o_rng  = r_rng;
    assign o_cell = r_cell;

    // counters
    always_comb begin
        int cnt;
        cnt        = int'(r_ranges);
        n_rng      = r_rng;
        n_rng_end  = r_rng_end;
        n_last_rng = r_last_rng;
        n_cell     = r_cell;
        n_act      = r_act;
        n_any      = r_any;
        if (cnt == 0) cnt = 1;
        if (cnt > NUM_RANGES) cnt = NUM_RANGES;
        unique case (r_state)
            ST_IDLE: begin
                if (tick) begin
                    n_rng     = '0;
                    n_cell    = '0;
                    n_act     = '0;
                    n_any     = 1'b0;
                    n_rng_end = RW'(cnt - 1);
                end
            end
            ST_PHASE: begin
                n_act[r_rng] = act_now;
                if (act_now) begin
                    n_last_rng = r_rng;
                    n_any      = 1'b1;
                end
                n_rng = at_end ? '0 : r_rng + RW'(1);
            end
            ST_WALK: begin
                if (!walk_act) begin
                    n_rng = r_rng + RW'(1);
                end else if (i_sts.cell_end) begin
                    n_rng  = r_rng + RW'(1);
                    n_cell = '0;
                end else begin
                    n_cell = r_cell + CW'(1);
                end
            end
            ST_FLUSH: n_cell = '0;
            default:  n_cell = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ranges   <= RANGES_RESET;
            r_rng      <= '0;
            r_rng_end  <= '0;
            r_last_rng <= '0;
            r_cell     <= '0;
            r_act      <= '0;
            r_any      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rng      <= n_rng;
            r_rng_end  <= n_rng_end;
            r_last_rng <= n_last_rng;
            r_cell     <= n_cell;
            r_act      <= n_act;
            r_any      <= n_any;
            if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_RANGES_IN_USE)) begin
                r_ranges <= i_cfg_ranges;
            end
        end
    end

endmodule

// ----- design/pcc_datapath.sv -----
// pcc_datapath: range registers, phase arithmetic, cell and color memories
// depends on pcc_pkg; commanded by pcc_ctrl

module pcc_datapath import pcc_pkg::*; #(
    parameter int NUM_RANGES = NUM_RANGES_DEF,
    parameter int MAX_CELLS  = MAX_CELLS_DEF,
    parameter int MAX_COLORS = MAX_COLORS_DEF,
    parameter int RW         = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1,
    parameter int CW         = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [RW-1:0]          i_rng,
    input  logic [CW-1:0]          i_cell,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [INC_W-1:0]       i_cfg_inc,
    input  logic [OP_W-1:0]        i_op,
    input  logic [RSEL_W-1:0]      i_range_sel,
    input  logic [ESEL_W-1:0]      i_entry_sel,
    input  logic [RATE_W-1:0]      i_rate_value,
    input  logic [CCNT_W-1:0]      i_color_count,
    input  logic [NCELL_W-1:0]     i_cell_count,
    input  logic [REG_W-1:0]       i_reg_number,
    input  logic [START_POS_W-1:0] i_start_position,
    input  logic [COLOR_W-1:0]     i_color_word,
    output logic                   o_strobe,
    output logic [REG_W-1:0]       o_color_register,
    output logic [COLOR_W-1:0]     o_color_value,
    output logic                   o_last_flag
);

    localparam int CCW    = $clog2(MAX_COLORS + 1);
    localparam int CNTW   = $clog2(MAX_CELLS + 1);
    localparam int PW     = ($clog2(MAX_COLORS) > START_POS_W) ? $clog2(MAX_COLORS)
                                                               : START_POS_W;
    localparam int CELL_D = NUM_RANGES * MAX_CELLS;
    localparam int COL_D  = NUM_RANGES * MAX_COLORS;
    localparam int CAW    = (CELL_D > 1) ? $clog2(CELL_D) : 1;
    localparam int KAW    = (COL_D > 1) ? $clog2(COL_D) : 1;
    localparam int SUM_W  = PHASE_W + 1;
    localparam int CWORD  = REG_W + PW;

    logic [INC_W-1:0]   r_inc;
    logic [PHASE_W-1:0] r_phase [NUM_RANGES];
    logic [RATE_W-1:0]  r_rate  [NUM_RANGES];
    logic [CCW-1:0]     r_ccnt  [NUM_RANGES];
    logic [CNTW-1:0]    r_ncell [NUM_RANGES];

    logic [CWORD-1:0]   mem_cell [CELL_D];
    logic [COLOR_W-1:0] mem_col  [COL_D];

    logic [CWORD-1:0]   r_cell_q;
    logic [COLOR_W-1:0] r_col_q;
    logic               r_s1_vld, r_s1_last;
    logic [RW-1:0]      r_s1_rng;
    logic [CAW-1:0]     r_s1_addr;
    logic               r_s2_vld, r_s2_last;
    logic [REG_W-1:0]   r_s2_reg;

    logic [SUM_W-1:0]   sum, diff;
    logic               fire;
    logic [PHASE_W-1:0] phase_new;
    logic               rsel_ok, setup_hit, cell_hit, color_hit;
    logic [CCW-1:0]     cc_sat;
    logic [CNTW-1:0]    cells_sat;
    logic [PW-1:0]      new_pos;
    logic               cell_we;
    logic [CAW-1:0]     cell_waddr, walk_addr;
    logic [CWORD-1:0]   cell_wdata;
    logic [KAW-1:0]     col_waddr, col_raddr;

    // phase update
    always_comb begin
        sum  = {1'b0, r_phase[i_rng]} + SUM_W'(r_inc);
        fire = (sum >= SUM_W'(r_rate[i_rng]));
        diff = fire ? sum - SUM_W'(r_rate[i_rng]) : sum;
        phase_new = (diff > SUM_W'(PHASE_MAX)) ? PHASE_W'(PHASE_MAX) : diff[PHASE_W-1:0];
    end

    assign o_sts.fire      = fire;
    assign o_sts.has_cells = (r_ncell[i_rng] != '0);
    assign o_sts.cell_end  = ((int'(i_cell) + 1) == int'(r_ncell[i_rng]));

    // load decode
    assign rsel_ok   = (int'(i_range_sel) < NUM_RANGES);
    assign setup_hit = i_cmd.load && rsel_ok && (t_op'(i_op) == OP_SETUP);
    assign cell_hit  = i_cmd.load && rsel_ok && (t_op'(i_op) == OP_CELL)
                       && (int'(i_entry_sel) < MAX_CELLS);
    assign color_hit = i_cmd.load && rsel_ok && (t_op'(i_op) == OP_COLOR)
                       && (int'(i_entry_sel) < MAX_COLORS);
    assign cc_sat    = (int'(i_color_count) > MAX_COLORS) ? CCW'(MAX_COLORS)
                                                          : CCW'(i_color_count);
    assign cells_sat = (int'(i_cell_count) > MAX_CELLS) ? CNTW'(MAX_CELLS)
                                                        : CNTW'(i_cell_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= INC_RESET;
            for (int i = 0; i < NUM_RANGES; i++) begin
                r_phase[i] <= '0;
                r_rate[i]  <= '0;
                r_ccnt[i]  <= CCW'(1);
                r_ncell[i] <= '0;
            end
        end else begin
            if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_PHASE_INC)) begin
                r_inc <= i_cfg_inc;
            end
            for (int i = 0; i < NUM_RANGES; i++) begin
                if (setup_hit && (int'(i_range_sel) == i)) begin
                    r_rate[i]  <= i_rate_value;
                    r_ccnt[i]  <= cc_sat;
                    r_ncell[i] <= cells_sat;
                    r_phase[i] <= '0;
                end else if (i_cmd.phase && (int'(i_rng) == i)) begin
                    r_phase[i] <= phase_new;
                end
            end
        end
    end

    // cell advance
    always_comb begin
        if ((int'(r_cell_q[PW-1:0]) + 1) >= int'(r_ccnt[r_s1_rng])) begin
            new_pos = '0;
        end else begin
            new_pos = r_cell_q[PW-1:0] + PW'(1);
        end
    end

    assign walk_addr  = CAW'(int'(i_rng) * MAX_CELLS + int'(i_cell));
    assign cell_we    = r_s1_vld || cell_hit;
    assign cell_waddr = r_s1_vld ? r_s1_addr
                                 : CAW'(int'(i_range_sel) * MAX_CELLS + int'(i_entry_sel));
    assign cell_wdata = r_s1_vld ? {r_cell_q[PW +: REG_W], new_pos}
                                 : {i_reg_number, PW'(i_start_position)};
    assign col_waddr  = KAW'(int'(i_range_sel) * MAX_COLORS + int'(i_entry_sel));
    assign col_raddr  = KAW'(int'(r_s1_rng) * MAX_COLORS + int'(new_pos));

    always_ff @(posedge i_clk) begin
        if (cell_we) mem_cell[cell_waddr] <= cell_wdata;
        if (i_cmd.walk) r_cell_q <= mem_cell[walk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (color_hit) mem_col[col_waddr] <= i_color_word;
        if (r_s1_vld) r_col_q <= mem_col[col_raddr];
    end

    // read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.walk;
            r_s1_last <= i_cmd.walk_last;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_vld && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_s1_rng  <= i_rng;
            r_s1_addr <= walk_addr;
        end
        if (r_s1_vld) r_s2_reg <= r_cell_q[PW +: REG_W];
    end

    assign o_strobe         = r_s2_vld;
    assign o_color_register = r_s2_reg;
    assign o_color_value    = r_col_q;
    assign o_last_flag      = r_s2_last;

endmodule

// ----- design/palette_color_cycler_unit.sv -----
// palette_color_cycler_unit: top level of the palette color cycler
// depends on pcc_pkg, pcc_ctrl and pcc_datapath
//
// channel   direction  handshake                    payload
// command   in         start & !busy                i_op .. i_color_word
// result    out        o_strobe, one cycle          o_color_register, o_color_value,
//                                                   o_last_flag
// config    in         i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
// a load transaction is applied when accepted; a tick runs a phase pass over each
// range in use (clamped to 1..NUM_RANGES), then, if any range fires, walks each cell
// of each firing range, stepping past non-firing ones below the last, then flushes
// results follow the cell and then the color memory read, one cell per cycle at most
// synchronous active-low reset returns all range registers to their reset values
// results cannot be stalled; busy falls in the cycle that shows the final result, if any

module palette_color_cycler_unit import pcc_pkg::*; #(
    parameter int NUM_RANGES = NUM_RANGES_DEF,
    parameter int MAX_CELLS  = MAX_CELLS_DEF,
    parameter int MAX_COLORS = MAX_COLORS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        i_op,
    input  logic [RSEL_W-1:0]      i_range_sel,
    input  logic [ESEL_W-1:0]      i_entry_sel,
    input  logic [RATE_W-1:0]      i_rate_value,
    input  logic [CCNT_W-1:0]      i_color_count,
    input  logic [NCELL_W-1:0]     i_cell_count,
    input  logic [REG_W-1:0]       i_reg_number,
    input  logic [START_POS_W-1:0] i_start_position,
    input  logic [COLOR_W-1:0]     i_color_word,
    output logic                   o_strobe,
    output logic [REG_W-1:0]       o_color_register,
    output logic [COLOR_W-1:0]     o_color_value,
    output logic                   o_last_flag,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int RW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [RW-1:0] rng;
    logic [CW-1:0] walk_cell;

    pcc_ctrl #(
        .NUM_RANGES (NUM_RANGES),
        .MAX_CELLS  (MAX_CELLS),
        .RW         (RW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_op         (i_op),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_ranges (i_cfg_wdata[RANGES_W-1:0]),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_rng        (rng),
        .o_cell       (walk_cell),
        .o_busy       (busy)
    );

    pcc_datapath #(
        .NUM_RANGES (NUM_RANGES),
        .MAX_CELLS  (MAX_CELLS),
        .MAX_COLORS (MAX_COLORS),
        .RW         (RW),
        .CW         (CW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rng            (rng),
        .i_cell           (walk_cell),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_inc        (i_cfg_wdata[INC_W-1:0]),
        .i_op             (i_op),
        .i_range_sel      (i_range_sel),
        .i_entry_sel      (i_entry_sel),
        .i_rate_value     (i_rate_value),
        .i_color_count    (i_color_count),
        .i_cell_count     (i_cell_count),
        .i_reg_number     (i_reg_number),
        .i_start_position (i_start_position),
        .i_color_word     (i_color_word),
        .o_strobe         (o_strobe),
        .o_color_register (o_color_register),
        .o_color_value    (o_color_value),
        .o_last_flag      (o_last_flag)
    );

endmodule

// ----- design/pcc_checker.sv -----
// pcc_checker: port-level assertions for palette_color_cycler_unit
// depends on pcc_pkg; attached to the top level by the bind below

module pcc_checker import pcc_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic [OP_W-1:0] i_op,
    input logic            o_strobe,
    input logic            o_last_flag
);

    // last flag only on a result
    a_last_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_flag |-> o_strobe)
        else $error("last flag without result");

    // a load transaction never makes the block busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_op'(i_op) != OP_TICK)) |=> !busy)
        else $error("load left block busy");

    // a tick always runs at least the phase pass
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_op'(i_op) == OP_TICK)) |=> busy)
        else $error("tick not started");

    // results only follow busy cycles
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without tick in progress");

    // the final result of a tick is not followed directly by another
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_flag |=> !o_strobe)
        else $error("result after last flag");

endmodule

bind palette_color_cycler_unit pcc_checker u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_op        (i_op),
    .o_strobe    (o_strobe),
    .o_last_flag (o_last_flag)
);

// ----- verif/palette_color_cycler_unit_tb.sv -----
// palette_color_cycler_unit_tb: self-checking testbench for the palette color cycler
// predicts every palette update from frame ticks and load transactions, checks them in order
// depends on pcc_pkg and palette_color_cycler_unit

`timescale 1ns / 100ps

module palette_color_cycler_unit_tb;
    import pcc_pkg::*;

    localparam int SLOTS           = NUM_RANGES_DEF * MAX_CELLS_DEF;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct {
        t_op                    op;
        logic [RSEL_W-1:0]      range_sel;
        logic [ESEL_W-1:0]      entry_sel;
        logic [RATE_W-1:0]      rate_value;
        logic [CCNT_W-1:0]      color_count;
        logic [NCELL_W-1:0]     cell_count;
        logic [REG_W-1:0]       reg_number;
        logic [START_POS_W-1:0] start_position;
        logic [COLOR_W-1:0]     color_word;
    } t_command;

    typedef struct packed {
        logic [REG_W-1:0]   pal_reg;
        logic [COLOR_W-1:0] value;
        logic               last;
    } t_update;

    class palette_update_tracker;
        int unsigned            mismatches;
        t_update                pending[$];
        int                     need_cells[$];
        int                     need_colors[$];
        logic [INC_W-1:0]       phase_inc;
        logic [RANGES_W-1:0]    ranges_cfg;
        int unsigned            phase[NUM_RANGES_DEF];
        int unsigned            rate[NUM_RANGES_DEF];
        int unsigned            color_span[NUM_RANGES_DEF];
        int unsigned            cell_span[NUM_RANGES_DEF];
        logic [REG_W-1:0]       cell_reg[SLOTS];
        int unsigned            cell_pos[SLOTS];
        logic [COLOR_W-1:0]     palette[SLOTS];
        bit                     cell_written[SLOTS];
        bit                     color_written[SLOTS];

        function new();
            mismatches = 0;
            phase_inc  = INC_RESET;
            ranges_cfg = RANGES_RESET;
            for (int r = 0; r < NUM_RANGES_DEF; r++) begin
                phase[r]      = 0;
                rate[r]       = 0;
                color_span[r] = 1;
                cell_span[r]  = 0;
            end
            for (int k = 0; k < SLOTS; k++) begin
                cell_written[k]  = 1'b0;
                color_written[k] = 1'b0;
            end
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PHASE_INC)
                phase_inc = data[INC_W-1:0];
            else
                ranges_cfg = data[RANGES_W-1:0];
        endfunction

        function int unsigned active_ranges();
            if (ranges_cfg == 0)
                return 1;
            if (ranges_cfg > NUM_RANGES_DEF)
                return NUM_RANGES_DEF;
            return ranges_cfg;
        endfunction

        // entries that the next tick would read but that were never loaded
        function void find_unwritten();
            int unsigned span;
            need_cells.delete();
            need_colors.delete();
            for (int r = 0; r < active_ranges(); r++) begin
                if (cell_span[r] != 0) begin
                    for (int c = 0; c < cell_span[r]; c++)
                        if (!cell_written[r * MAX_CELLS_DEF + c])
                            need_cells.push_back(r * MAX_CELLS_DEF + c);
                    span = (color_span[r] == 0) ? 1 : color_span[r];
                    for (int p = 0; p < span; p++)
                        if (!color_written[r * MAX_COLORS_DEF + p])
                            need_colors.push_back(r * MAX_COLORS_DEF + p);
                end
            end
        endfunction

        function void accept_command(t_command c);
            int unsigned p;
            int unsigned pos;
            int unsigned k;
            bit          fire;
            t_update     fresh[$];
            t_update     u;
            case (c.op)
                OP_TICK: begin
                    for (int r = 0; r < active_ranges(); r++) begin
                        p = phase[r] + phase_inc;
                        fire = (p >= rate[r]);
                        if (fire)
                            p = p - rate[r];
                        if (p > PHASE_MAX)
                            p = PHASE_MAX;
                        phase[r] = p;
                        if (fire) begin
                            for (int n = 0; n < cell_span[r]; n++) begin
                                k = r * MAX_CELLS_DEF + n;
                                pos = cell_pos[k] + 1;
                                if (pos >= color_span[r])
                                    pos = 0;
                                cell_pos[k] = pos;
                                u.pal_reg = cell_reg[k];
                                u.value   = palette[r * MAX_COLORS_DEF + pos];
                                u.last    = 1'b0;
                                fresh.push_back(u);
                            end
                        end
                    end
                    if (fresh.size() != 0)
                        fresh[fresh.size() - 1].last = 1'b1;
                    foreach (fresh[i])
                        pending.push_back(fresh[i]);
                end
                OP_SETUP: begin
                    rate[c.range_sel]       = c.rate_value;
                    color_span[c.range_sel] = (c.color_count > MAX_COLORS_DEF) ?
                                              MAX_COLORS_DEF : c.color_count;
                    cell_span[c.range_sel]  = (c.cell_count > MAX_CELLS_DEF) ?
                                              MAX_CELLS_DEF : c.cell_count;
                    phase[c.range_sel]      = 0;
                end
                OP_CELL: begin
                    k = c.range_sel * MAX_CELLS_DEF + c.entry_sel;
                    cell_reg[k]     = c.reg_number;
                    cell_pos[k]     = c.start_position;
                    cell_written[k] = 1'b1;
                end
                default: begin
                    k = c.range_sel * MAX_COLORS_DEF + c.entry_sel;
                    palette[k]       = c.color_word;
                    color_written[k] = 1'b1;
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_update(logic [REG_W-1:0] pal_reg, logic [COLOR_W-1:0] value, logic last);
            t_update want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected update reg %0d value %03h last %b",
                                          pal_reg, value, last));
            end else begin
                want = pending.pop_front();
                if (pal_reg !== want.pal_reg || value !== want.value || last !== want.last)
                    report_mismatch($sformatf(
                        "got reg %0d value %03h last %b, expected reg %0d value %03h last %b",
                        pal_reg, value, last, want.pal_reg, want.value, want.last));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OP_W-1:0]        i_op = '0;
    logic [RSEL_W-1:0]      i_range_sel = '0;
    logic [ESEL_W-1:0]      i_entry_sel = '0;
    logic [RATE_W-1:0]      i_rate_value = '0;
    logic [CCNT_W-1:0]      i_color_count = '0;
    logic [NCELL_W-1:0]     i_cell_count = '0;
    logic [REG_W-1:0]       i_reg_number = '0;
    logic [START_POS_W-1:0] i_start_position = '0;
    logic [COLOR_W-1:0]     i_color_word = '0;
    logic                   o_strobe;
    logic [REG_W-1:0]       o_color_register;
    logic [COLOR_W-1:0]     o_color_value;
    logic                   o_last_flag;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    palette_update_tracker tracker;
    int unsigned           idle_pct = 0;
    int unsigned           cycle_count = 0;

    palette_color_cycler_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_range_sel      (i_range_sel),
        .i_entry_sel      (i_entry_sel),
        .i_rate_value     (i_rate_value),
        .i_color_count    (i_color_count),
        .i_cell_count     (i_cell_count),
        .i_reg_number     (i_reg_number),
        .i_start_position (i_start_position),
        .i_color_word     (i_color_word),
        .o_strobe         (o_strobe),
        .o_color_register (o_color_register),
        .o_color_value    (o_color_value),
        .o_last_flag      (o_last_flag),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            tracker.check_update(o_color_register, o_color_value, o_last_flag);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("palette_color_cycler_unit_tb failed");
        $finish;
    end

    function automatic t_command random_command(t_op op);
        t_command c;
        c.op             = op;
        c.range_sel      = RSEL_W'($urandom);
        c.entry_sel      = ESEL_W'($urandom);
        c.rate_value     = RATE_W'($urandom);
        c.color_count    = CCNT_W'($urandom);
        c.cell_count     = NCELL_W'($urandom);
        c.reg_number     = REG_W'($urandom);
        c.start_position = START_POS_W'($urandom);
        c.color_word     = COLOR_W'($urandom);
        return c;
    endfunction

    task automatic drive_command(input t_command c);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
        end
        start            <= 1'b1;
        i_op             <= c.op;
        i_range_sel      <= c.range_sel;
        i_entry_sel      <= c.entry_sel;
        i_rate_value     <= c.rate_value;
        i_color_count    <= c.color_count;
        i_cell_count     <= c.cell_count;
        i_reg_number     <= c.reg_number;
        i_start_position <= c.start_position;
        i_color_word     <= c.color_word;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        tracker.accept_command(c);
    endtask

    // a tick is preceded by loads of any cell or color it would read unwritten
    task automatic issue(input t_command c);
        t_command fill;
        int       slots[$];
        if (c.op == OP_TICK) begin
            tracker.find_unwritten();
            slots = tracker.need_cells;
            foreach (slots[i]) begin
                fill = random_command(OP_CELL);
                fill.range_sel = RSEL_W'(slots[i] / MAX_CELLS_DEF);
                fill.entry_sel = ESEL_W'(slots[i] % MAX_CELLS_DEF);
                drive_command(fill);
            end
            slots = tracker.need_colors;
            foreach (slots[i]) begin
                fill = random_command(OP_COLOR);
                fill.range_sel = RSEL_W'(slots[i] / MAX_COLORS_DEF);
                fill.entry_sel = ESEL_W'(slots[i] % MAX_COLORS_DEF);
                drive_command(fill);
            end
        end
        drive_command(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [INC_W-1:0] inc, input logic [RANGES_W-1:0] ranges);
        logic [CFG_DATA_W-1:0] data;
        data        = {(CFG_DATA_W - RANGES_W)'($urandom), ranges};
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_PHASE_INC;
        i_cfg_wdata <= inc;
        @(posedge i_clk);
        tracker.write_register(CFG_PHASE_INC, inc);
        i_cfg_idx   <= CFG_RANGES_IN_USE;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.write_register(CFG_RANGES_IN_USE, data);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_item();
        t_command    c;
        int unsigned pick;
        c = random_command(OP_TICK);
        pick = $urandom_range(99);
        if (pick >= 35 && pick < 47) begin
            c.op = OP_SETUP;
            pick = $urandom_range(99);
            if (pick < 20)
                c.rate_value = '0;
            else if (pick < 70)
                c.rate_value = RATE_W'($urandom_range(0, 4000));
            if ($urandom_range(99) < 70)
                c.color_count = CCNT_W'($urandom_range(1, MAX_COLORS_DEF));
            if ($urandom_range(99) < 75)
                c.cell_count = NCELL_W'($urandom_range(0, 6));
        end else if (pick >= 47 && pick < 75) begin
            c.op = OP_CELL;
        end else if (pick >= 75) begin
            c.op = OP_COLOR;
        end
        issue(c);
    endtask

    initial begin
        t_command         c;
        logic [REG_W-1:0] regs[3];
        int unsigned      spots[3];
        logic [COLOR_W-1:0] hues[4];
        logic [INC_W-1:0]   inc;
        logic [RANGES_W-1:0] ranges;
        int unsigned        phase_idle[6];
        regs       = '{5'd0, 5'd31, 5'd17};
        spots      = '{0, 3, 15};
        hues       = '{12'h000, 12'hFFF, 12'hABC, 12'h5A5};
        phase_idle = '{0, 88, 6, 0, 88, 6};
        tracker    = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tick with nothing loaded, rate zero, wraps, zero colors, saturation
        issue(random_command(OP_TICK));
        c = random_command(OP_SETUP);
        c.range_sel = '0; c.rate_value = '0; c.color_count = 5'd4; c.cell_count = 5'd3;
        issue(c);
        for (int i = 0; i < 3; i++) begin
            c = random_command(OP_CELL);
            c.range_sel = '0; c.entry_sel = ESEL_W'(i);
            c.reg_number = regs[i]; c.start_position = START_POS_W'(spots[i]);
            issue(c);
        end
        for (int i = 0; i < 4; i++) begin
            c = random_command(OP_COLOR);
            c.range_sel = '0; c.entry_sel = ESEL_W'(i); c.color_word = hues[i];
            issue(c);
        end
        issue(random_command(OP_TICK));
        issue(random_command(OP_TICK));
        c = random_command(OP_SETUP);
        c.range_sel = '0; c.rate_value = '0; c.color_count = '0; c.cell_count = 5'd2;
        issue(c);
        issue(random_command(OP_TICK));
        c = random_command(OP_SETUP);
        c.range_sel = '0; c.rate_value = '1; c.color_count = '1; c.cell_count = 5'd1;
        issue(c);
        issue(random_command(OP_TICK));
        drain();
        write_config('1, '0);
        c = random_command(OP_SETUP);
        c.range_sel = '0; c.rate_value = RATE_W'(1); c.color_count = 5'd2; c.cell_count = 5'd2;
        issue(c);
        repeat (3) issue(random_command(OP_TICK));

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin inc = INC_RESET;     ranges = 3'd4; end
                1: begin inc = '1;            ranges = 3'd7; end
                2: begin inc = '0;            ranges = 3'd2; end
                3: begin inc = INC_W'($urandom); ranges = 3'd0; end
                4: begin inc = INC_W'(1);     ranges = 3'd3; end
                default: begin
                    inc = INC_W'($urandom_range(0, 3000));
                    ranges = RANGES_W'($urandom_range(1, NUM_RANGES_DEF));
                end
            endcase
            drain();
            write_config(inc, ranges);
            idle_pct = phase_idle[ph];
            repeat (ITEMS_PER_PHASE) random_item();
        end
        drain();

        if (tracker.mismatches == 0)
            $display("palette_color_cycler_unit_tb passed");
        else
            $display("palette_color_cycler_unit_tb failed");
        $finish;
    end

endmodule
